// ----- rtl/ddep_pkg.sv -----
// Shared types, constants and the seven-segment font for the duty editor panel.
// No dependencies; every other file but the checker refers to it by scoped names.
package ddep_pkg;

  // Debouncer phases
  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_DB_PRESS   = 2'd1,
    PH_HELD       = 2'd2,
    PH_DB_RELEASE = 2'd3
  } phase_e;

  // Configuration register indexes (byte address 4*i)
  typedef enum logic {
    REG_DEBOUNCE_LIMIT = 1'b0,
    REG_BLINK_PERIOD   = 1'b1
  } reg_idx_e;

  // Button lane numbers within button_levels
  localparam int unsigned NumButtons = 4;
  localparam int unsigned BtnUp      = 0;
  localparam int unsigned BtnDown    = 1;
  localparam int unsigned BtnLeft    = 2;
  localparam int unsigned BtnRight   = 3;

  localparam logic [7:0]  LimitReset  = 8'd5;
  localparam logic [15:0] PeriodReset = 16'd1000;
  localparam logic [9:0]  DutyMax     = 10'd1000;
  localparam logic [9:0]  DutyReset   = 10'd500;
  localparam logic [9:0]  PwmLast     = 10'd999;
  localparam logic [7:0]  DpMask      = 8'h80;
  localparam logic [7:0]  SegBlank    = 8'hFF;

  // Digit state carried from the update logic into the display pipeline
  typedef struct packed {
    logic [9:0] duty;     // duty after this tick's edits
    logic [9:0] pwm;      // pwm phase after this tick
    logic [1:0] digit;    // digit scanned this tick
    logic       blank;    // cursor digit blanked by blink
  } snap_t;

  // Active-high segments a..g, decimal point off
  function automatic logic [7:0] seg_font(logic [3:0] d);
    logic [7:0] f;
    case (d)
      4'd0:    f = 8'h3F;
      4'd1:    f = 8'h06;
      4'd2:    f = 8'h5B;
      4'd3:    f = 8'h4F;
      4'd4:    f = 8'h66;
      4'd5:    f = 8'h6D;
      4'd6:    f = 8'h7D;
      4'd7:    f = 8'h07;
      4'd8:    f = 8'h7F;
      4'd9:    f = 8'h6F;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

// ----- rtl/ddep_lane.sv -----
// One button debouncer lane: four-phase state machine with a hold counter.
// Depends on ddep_pkg for the phase type.
module ddep_lane (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       level_i,
  input  logic [7:0] limit_i,
  output logic       fire_o
);

  ddep_pkg::phase_e phase_q, phase_d;
  logic [7:0]       count_q, count_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ddep_pkg::PH_IDLE;
      count_q <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  // Next phase, counter and press pulse
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    fire_o  = 1'b0;
    unique case (phase_q)
      ddep_pkg::PH_IDLE: begin
        if (level_i) begin
          count_d = '0;
          phase_d = ddep_pkg::PH_DB_PRESS;
        end
      end
      ddep_pkg::PH_DB_PRESS: begin
        if (!level_i) begin
          phase_d = ddep_pkg::PH_IDLE;
        end else if (count_q < limit_i) begin
          count_d = count_q + 8'd1;
        end else begin
          fire_o  = 1'b1;
          phase_d = ddep_pkg::PH_HELD;
        end
      end
      ddep_pkg::PH_HELD: begin
        if (!level_i) begin
          count_d = '0;
          phase_d = ddep_pkg::PH_DB_RELEASE;
        end
      end
      ddep_pkg::PH_DB_RELEASE: begin
        if (level_i) begin
          phase_d = ddep_pkg::PH_HELD;
        end else if (count_q < limit_i) begin
          count_d = count_q + 8'd1;
        end else begin
          phase_d = ddep_pkg::PH_IDLE;
        end
      end
      default: phase_d = ddep_pkg::PH_IDLE;
    endcase
  end

endmodule

// ----- rtl/ddep_merge.sv -----
// Merge stage: combines the four lane pulses into cursor and duty edits and
// advances the scan, blink and PWM counters. Depends on ddep_pkg.
module ddep_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [3:0]            fire_i,
  input  logic [15:0]           period_i,
  output ddep_pkg::snap_t       snap_o
);

  logic [1:0]  cursor_q, cursor_d;
  logic [9:0]  duty_q, duty_d;
  logic [1:0]  scan_q, scan_d;
  logic [15:0] blink_q, blink_d;
  logic [9:0]  pwm_q, pwm_d;

  logic [1:0]  cursor_rt;
  logic [9:0]  step;
  logic [10:0] sum;
  logic [9:0]  duty_up;
  logic [16:0] blink_inc;

  // Cursor: right first, then left; a wrap over four digits
  always_comb begin
    cursor_rt = fire_i[ddep_pkg::BtnRight] ? cursor_q + 2'd1 : cursor_q;
    cursor_d  = fire_i[ddep_pkg::BtnLeft] ? cursor_rt - 2'd1 : cursor_rt;
  end

  // Step weight of the selected digit
  always_comb begin
    case (cursor_d)
      2'd0:    step = 10'd1000;
      2'd1:    step = 10'd100;
      2'd2:    step = 10'd10;
      default: step = 10'd1;
    endcase
  end

  // Duty edit: clamped add, then floored subtract
  always_comb begin
    sum     = {1'b0, duty_q} + {1'b0, step};
    duty_up = duty_q;
    if (fire_i[ddep_pkg::BtnUp]) begin
      duty_up = (sum > {1'b0, ddep_pkg::DutyMax}) ? ddep_pkg::DutyMax : sum[9:0];
    end
    duty_d = duty_up;
    if (fire_i[ddep_pkg::BtnDown]) begin
      duty_d = (duty_up < step) ? 10'd0 : duty_up - step;
    end
  end

  // Free-running counters
  always_comb begin
    scan_d    = scan_q + 2'd1;
    blink_inc = {1'b0, blink_q} + 17'd1;
    blink_d   = (blink_inc >= {1'b0, period_i}) ? 16'd0 : blink_inc[15:0];
    pwm_d     = (pwm_q >= ddep_pkg::PwmLast) ? 10'd0 : pwm_q + 10'd1;
  end

  // What the display needs from this tick
  always_comb begin
    snap_o.duty  = duty_d;
    snap_o.pwm   = pwm_d;
    snap_o.digit = scan_q;
    snap_o.blank = (scan_q == cursor_d) && (blink_q < (period_i >> 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      duty_q   <= ddep_pkg::DutyReset;
      scan_q   <= '0;
      blink_q  <= '0;
      pwm_q    <= '0;
    end else if (en_i) begin
      cursor_q <= cursor_d;
      duty_q   <= duty_d;
      scan_q   <= scan_d;
      blink_q  <= blink_d;
      pwm_q    <= pwm_d;
    end
  end

endmodule

// ----- rtl/ddep_display.sv -----
// Display pipeline: snapshot, hundreds split with PWM compare, then tens split,
// font lookup and output register. Three stages with elastic flow control.
// Depends on ddep_pkg.
module ddep_display (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  ddep_pkg::snap_t snap_i,
  output logic            stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [3:0]      anode_o,
  output logic [7:0]      seg_o,
  output logic            led_o
);

  logic va_q, vb_q, vc_q;
  logic load_a, load_b, load_c;

  ddep_pkg::snap_t snap_q;

  logic       thou_q;
  logic [3:0] hund_q;
  logic [6:0] rem_q;
  logic [1:0] digit_b_q;
  logic       blank_b_q;
  logic       led_b_q;

  logic [3:0] anode_q;
  logic [7:0] seg_q;
  logic       led_q;

  logic       thou;
  logic [9:0] rem_lo;
  logic [3:0] hund;
  logic [6:0] rem_h;
  logic [3:0] tens;
  logic [3:0] units;
  logic [3:0] dval;
  logic [7:0] seg;

  // Stage enables: a stage loads when empty or when it empties this cycle
  always_comb begin
    load_c  = vb_q && (!vc_q || !out_stall_i);
    load_b  = va_q && (!vb_q || load_c);
    load_a  = valid_i && (!va_q || load_b);
    stall_o = va_q && !load_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (load_a) begin
        va_q <= 1'b1;
      end else if (load_b) begin
        va_q <= 1'b0;
      end
      if (load_b) begin
        vb_q <= 1'b1;
      end else if (load_c) begin
        vb_q <= 1'b0;
      end
      if (load_c) begin
        vc_q <= 1'b1;
      end else if (!out_stall_i) begin
        vc_q <= 1'b0;
      end
    end
  end

  // Stage A: snapshot of the tick
  always_ff @(posedge clk_i) begin
    if (load_a) begin
      snap_q <= snap_i;
    end
  end

  // Hundreds split by compare ladder; duty never exceeds 1000
  always_comb begin
    thou   = (snap_q.duty >= ddep_pkg::DutyMax);
    rem_lo = thou ? 10'd0 : snap_q.duty;
    hund   = 4'd0;
    rem_h  = rem_lo[6:0];
    for (int i = 1; i < 10; i++) begin
      if (rem_lo >= 10'(i * 100)) begin
        hund  = 4'(i);
        rem_h = 7'(rem_lo - 10'(i * 100));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_b) begin
      thou_q    <= thou;
      hund_q    <= hund;
      rem_q     <= rem_h;
      digit_b_q <= snap_q.digit;
      blank_b_q <= snap_q.blank;
      led_b_q   <= (snap_q.pwm < snap_q.duty);
    end
  end

  // Tens and units split, digit select and segment pattern
  always_comb begin
    tens  = 4'd0;
    units = rem_q[3:0];
    for (int i = 1; i < 10; i++) begin
      if (rem_q >= 7'(i * 10)) begin
        tens  = 4'(i);
        units = 4'(rem_q - 7'(i * 10));
      end
    end
    case (digit_b_q)
      2'd0:    dval = {3'b000, thou_q};
      2'd1:    dval = hund_q;
      2'd2:    dval = tens;
      default: dval = units;
    endcase
    seg = blank_b_q ? ddep_pkg::SegBlank : ~ddep_pkg::seg_font(dval);
    // digit 2 carries the lit decimal point, blanked or not
    if (digit_b_q == 2'd2) begin
      seg = seg ^ ddep_pkg::DpMask;
    end
  end

  // Stage C: output register
  always_ff @(posedge clk_i) begin
    if (load_c) begin
      anode_q <= ~(4'b1000 >> digit_b_q);
      seg_q   <= seg;
      led_q   <= led_b_q;
    end
  end

  assign out_valid_o = vc_q;
  assign anode_o     = anode_q;
  assign seg_o       = seg_q;
  assign led_o       = led_q;

endmodule

// ----- rtl/debounced_duty_editor_panel.sv -----
// Top level of the debounced duty editor panel: APB registers, four debounce
// lanes, merge stage and display pipeline. Depends on ddep_pkg and submodules.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o    | button_levels_i[3:0]
//  out     | out_valid_o / out_stall_i  | anode_enable_o, segment_drive_o,
//          |                            | pwm_led_o
//  config  | psel/penable/pwrite/pready | paddr[2:0], pwdata, prdata
//
// One tick item is taken every cycle while in_stall_o is low; its result passes
// through the snapshot, digit-split and output register stages.
// Button, cursor, duty and counter state advance at the transfer itself.
// A stalled output holds; input keeps flowing until all three stages are full.
// Reset gives limit 5, blink period 1000, duty 500, all buttons released.
module debounced_duty_editor_panel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  button_levels_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  anode_enable_o,
  output logic [7:0]  segment_drive_o,
  output logic        pwm_led_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  limit_q;
  logic [15:0] period_q;
  logic        cfg_wr;
  logic        accept;
  logic [3:0]  fire;

  ddep_pkg::reg_idx_e reg_idx;
  ddep_pkg::snap_t    snap;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = ddep_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= ddep_pkg::LimitReset;
      period_q <= ddep_pkg::PeriodReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ddep_pkg::REG_DEBOUNCE_LIMIT: limit_q  <= pwdata[7:0];
        ddep_pkg::REG_BLINK_PERIOD:   period_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ddep_pkg::REG_DEBOUNCE_LIMIT: prdata = {24'd0, limit_q};
      ddep_pkg::REG_BLINK_PERIOD:   prdata = {16'd0, period_q};
      default:                      prdata = '0;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  // One debouncer per button
  for (genvar b = 0; b < ddep_pkg::NumButtons; b++) begin : g_lane
    ddep_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (accept),
      .level_i (button_levels_i[b]),
      .limit_i (limit_q),
      .fire_o  (fire[b])
    );
  end

  ddep_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (accept),
    .fire_i   (fire),
    .period_i (period_q),
    .snap_o   (snap)
  );

  ddep_display u_display (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .snap_i      (snap),
    .stall_o     (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .anode_o     (anode_enable_o),
    .seg_o       (segment_drive_o),
    .led_o       (pwm_led_o)
  );

endmodule

// ----- rtl/ddep_checker.sv -----
// Port-level checks for the duty editor panel, bound to the top level.
// Sees only the top-level ports; no package dependency.
module ddep_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [3:0]  button_levels_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  anode_enable_o,
  input logic [7:0]  segment_drive_o,
  input logic        pwm_led_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // A stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(anode_enable_o)
      && $stable(segment_drive_o) && $stable(pwm_led_o))
    else $error("stalled result changed");

  // Exactly one digit enabled per result
  a_one_anode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(~anode_enable_o))
    else $error("anode enable not one-cold");

  // Digit 2 (bit 1 low) always shows its decimal point
  a_dp_digit2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (anode_enable_o == 4'b1101) |-> !segment_drive_o[7])
    else $error("decimal point missing on digit 2");

  // With the output side empty the input never stalls
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind debounced_duty_editor_panel ddep_checker u_ddep_checker (.*);

// ----- tb/debounced_duty_editor_panel_test.sv -----
// Self-checking bench for the debounced duty editor panel: directed table, then
// randomized press/release and noise phases under random stalls on both sides.
// Depends on ddep_pkg and the debounced_duty_editor_panel RTL.
module debounced_duty_editor_panel_test;

  // Run guard, generous against the slowest legal run
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [3:0] anode;
    logic [7:0] seg;
    logic       led;
  } frame_t;

  typedef enum logic {
    ROW_TICK = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    ddep_pkg::reg_idx_e sel;
    logic [15:0]       value;  // button levels for a tick, register data for a write
    bit                known;  // expected frame typed in below
    logic [3:0]        anode;
    logic [7:0]        seg;
    logic              led;
  } dir_row_t;

  // DUT connections
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  button_levels_i = 4'h0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  anode_enable_o;
  logic [7:0]  segment_drive_o;
  logic        pwm_led_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted panel state and register copies
  ddep_pkg::phase_e btn_phase [4];
  logic [7:0]       btn_count [4];
  logic [1:0]       cursor_pos;
  int               duty_now;
  logic [1:0]       scan_pos;
  logic [15:0]      blink_ph;
  int               pwm_ph;
  logic [7:0]       limit_cfg;
  logic [15:0]      period_cfg;

  // Active-high glyphs for decimal digits
  logic [7:0] glyph [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                             8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

  frame_t due_frames [$];
  int     mismatch_count = 0;
  int     frames_seen = 0;
  int     ticks_sent = 0;
  int     cycle_count = 0;
  bit     tx_burst = 1'b0;
  bit     rx_burst = 1'b0;

  // Directed table: reset view, then two-tick presses with a zero limit
  localparam int DirRows = 29;
  dir_row_t dir_table [DirRows] = '{
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b1, 4'h7, 8'hFF, 1'b1},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b1, 4'hB, 8'h92, 1'b1},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b1, 4'hD, 8'h40, 1'b1},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b1, 4'hE, 8'hC0, 1'b1},
    '{ROW_CFG,  ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b0, 4'h0, 8'h00, 1'b0},
    // up past the top: clamps at 1000
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h1, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h1, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b0, 4'h0, 8'h00, 1'b0},
    // up and down together
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h3, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h3, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b0, 4'h0, 8'h00, 1'b0},
    // down below zero
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h2, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h2, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b0, 4'h0, 8'h00, 1'b0},
    // left and right together cancel
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'hC, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'hC, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b0, 4'h0, 8'h00, 1'b0},
    // right alone, then up at the hundreds digit
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h8, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h8, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h1, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h1, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b0, 4'h0, 8'h00, 1'b0},
    '{ROW_TICK, ddep_pkg::REG_DEBOUNCE_LIMIT, 16'h0, 1'b0, 4'h0, 8'h00, 1'b0}
  };

  debounced_duty_editor_panel uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .button_levels_i (button_levels_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .anode_enable_o  (anode_enable_o),
    .segment_drive_o (segment_drive_o),
    .pwm_led_o       (pwm_led_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("debounced_duty_editor_panel_test: done, errors");
      $finish;
    end
  end

  // One debounce lane; returns the press pulse
  function automatic logic lane_step(int b, logic level);
    logic fire;
    fire = 1'b0;
    case (btn_phase[b])
      ddep_pkg::PH_IDLE: begin
        if (level) begin
          btn_count[b] = 8'd0;
          btn_phase[b] = ddep_pkg::PH_DB_PRESS;
        end
      end
      ddep_pkg::PH_DB_PRESS: begin
        if (!level) btn_phase[b] = ddep_pkg::PH_IDLE;
        else if (btn_count[b] < limit_cfg) btn_count[b] = btn_count[b] + 8'd1;
        else begin
          fire = 1'b1;
          btn_phase[b] = ddep_pkg::PH_HELD;
        end
      end
      ddep_pkg::PH_HELD: begin
        if (!level) begin
          btn_count[b] = 8'd0;
          btn_phase[b] = ddep_pkg::PH_DB_RELEASE;
        end
      end
      default: begin
        if (level) btn_phase[b] = ddep_pkg::PH_HELD;
        else if (btn_count[b] < limit_cfg) btn_count[b] = btn_count[b] + 8'd1;
        else btn_phase[b] = ddep_pkg::PH_IDLE;
      end
    endcase
    return fire;
  endfunction

  // Advance the predicted panel by one tick and return the frame it shows
  function automatic frame_t advance_panel(logic [3:0] lv);
    logic [3:0] pulse;
    int         step, dig;
    frame_t     f;
    for (int b = 0; b < ddep_pkg::NumButtons; b++) pulse[b] = lane_step(b, lv[b]);

    // cursor moves first, the edit uses the new cursor
    if (pulse[ddep_pkg::BtnRight]) cursor_pos = cursor_pos + 2'd1;
    if (pulse[ddep_pkg::BtnLeft])  cursor_pos = cursor_pos - 2'd1;
    case (cursor_pos)
      2'd0:    step = 1000;
      2'd1:    step = 100;
      2'd2:    step = 10;
      default: step = 1;
    endcase
    if (pulse[ddep_pkg::BtnUp]) begin
      duty_now = duty_now + step;
      if (duty_now > int'(ddep_pkg::DutyMax)) duty_now = int'(ddep_pkg::DutyMax);
    end
    if (pulse[ddep_pkg::BtnDown]) duty_now = (duty_now < step) ? 0 : duty_now - step;

    // digit scan with cursor blink, decimal point on digit 2
    case (scan_pos)
      2'd0:    dig = duty_now / 1000;
      2'd1:    dig = (duty_now / 100) % 10;
      2'd2:    dig = (duty_now / 10) % 10;
      default: dig = duty_now % 10;
    endcase
    if (dig > 9) dig = 9;
    f.seg = ~glyph[dig];
    if (scan_pos == cursor_pos && blink_ph < period_cfg / 16'd2) f.seg = ddep_pkg::SegBlank;
    if (scan_pos == 2'd2) f.seg = f.seg ^ ddep_pkg::DpMask;
    f.anode = ~(4'b0001 << (2'd3 - scan_pos));

    scan_pos = scan_pos + 2'd1;
    if (int'(blink_ph) + 1 >= int'(period_cfg)) blink_ph = 16'd0;
    else blink_ph = blink_ph + 16'd1;

    pwm_ph = (pwm_ph >= int'(ddep_pkg::PwmLast)) ? 0 : pwm_ph + 1;
    f.led = (pwm_ph < duty_now);
    return f;
  endfunction

  // Offer one tick item; on transfer, queue its expected frame
  task automatic send_tick(input logic [3:0] lv, input bit known = 1'b0,
                           input frame_t typed = '0);
    int     gap;
    frame_t f;
    if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    button_levels_i <= lv;
    do @(posedge clk_i); while (in_stall_o);
    f = advance_panel(lv);
    due_frames.push_back(known ? typed : f);
    ticks_sent++;
  endtask

  // Stop offering and let every queued frame come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (due_frames.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // APB write: setup phase, then access phase until pready, then back to idle
  task automatic reg_write(input ddep_pkg::reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == ddep_pkg::REG_DEBOUNCE_LIMIT) limit_cfg = val[7:0];
    else period_cfg = val[15:0];
    @(posedge clk_i);
  endtask

  task automatic set_config(input int limit, input int period);
    wait_drained();
    reg_write(ddep_pkg::REG_DEBOUNCE_LIMIT, 32'(limit));
    reg_write(ddep_pkg::REG_BLINK_PERIOD, 32'(period));
  endtask

  // Press with optional bounce on both edges, held past the limit
  task automatic press_sequence();
    logic [3:0] mask;
    int         n;
    if ($urandom_range(0, 9) < 7) mask = 4'b0001 << $urandom_range(0, 3);
    else mask = 4'($urandom_range(1, 15));
    if (limit_cfg > 0 && $urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, limit_cfg);
      repeat (n) send_tick(mask);
      send_tick(4'h0);
    end
    repeat (int'(limit_cfg) + 2 + $urandom_range(0, 6)) send_tick(mask);
    if (limit_cfg > 0 && $urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, limit_cfg);
      repeat (n) send_tick(4'h0);
      send_tick(mask);
    end
    repeat (int'(limit_cfg) + 2 + $urandom_range(0, 3)) send_tick(4'h0);
  endtask

  // Mostly clean presses, some raw noise
  task automatic run_phase(input int target);
    int start;
    start = ticks_sent;
    while (ticks_sent - start < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) send_tick(4'($urandom_range(0, 15)));
      end else begin
        press_sequence();
      end
    end
  endtask

  // Result side: random stalls, one long hold-off, frame compare
  initial begin
    int     gap;
    frame_t want;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      if (frames_seen == 120) gap = 60;
      else gap = rx_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      frames_seen++;
      if (due_frames.size() == 0) begin
        $error("unexpected transfer: anode_enable %h segment_drive %h pwm_led %b",
               anode_enable_o, segment_drive_o, pwm_led_o);
        mismatch_count++;
      end else begin
        want = due_frames.pop_front();
        if (anode_enable_o !== want.anode) begin
          $error("anode_enable: expected %h, got %h", want.anode, anode_enable_o);
          mismatch_count++;
        end
        if (segment_drive_o !== want.seg) begin
          $error("segment_drive: expected %h, got %h", want.seg, segment_drive_o);
          mismatch_count++;
        end
        if (pwm_led_o !== want.led) begin
          $error("pwm_led: expected %b, got %b", want.led, pwm_led_o);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    frame_t typed;
    for (int b = 0; b < ddep_pkg::NumButtons; b++) begin
      btn_phase[b] = ddep_pkg::PH_IDLE;
      btn_count[b] = 8'd0;
    end
    cursor_pos = 2'd0;
    duty_now   = int'(ddep_pkg::DutyReset);
    scan_pos   = 2'd0;
    blink_ph   = 16'd0;
    pwm_ph     = 0;
    limit_cfg  = ddep_pkg::LimitReset;
    period_cfg = ddep_pkg::PeriodReset;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        wait_drained();
        reg_write(dir_table[i].sel, 32'(dir_table[i].value));
      end else begin
        typed = '{anode: dir_table[i].anode, seg: dir_table[i].seg, led: dir_table[i].led};
        send_tick(dir_table[i].value[3:0], dir_table[i].known, typed);
      end
    end

    // random phases; shortest blink right after a long one wraps the phase
    set_config(3, 2);
    run_phase(150);
    set_config(0, 65535);
    run_phase(150);
    // one full press and release at the longest limit
    set_config(255, 1000);
    press_sequence();
    set_config($urandom_range(1, 10), $urandom_range(2, 60));
    run_phase(120);
    set_config($urandom_range(1, 10), $urandom_range(2, 60));
    run_phase(120);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("debounced_duty_editor_panel_test: done, clean");
    end else begin
      $display("debounced_duty_editor_panel_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- debounced_duty_editor_panel.f -----
rtl/ddep_pkg.sv
rtl/ddep_lane.sv
rtl/ddep_merge.sv
rtl/ddep_display.sv
rtl/debounced_duty_editor_panel.sv
rtl/ddep_checker.sv
tb/debounced_duty_editor_panel_test.sv
